// File: rtl/assert_macros.svh
// Assertion macros used by the rate limiter datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define SWRL_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SWRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/swrl_pkg.sv
// Shared types and constants of the sliding window rate limiter.
package swrl_pkg;

    // Default depths and client count
    localparam int SECOND_DEPTH_DEF = 64;
    localparam int MINUTE_DEPTH_DEF = 256;
    localparam int CLIENT_DEPTH_DEF = 64;
    localparam int NUM_CLIENTS_DEF  = 16;

    // Window lengths and time units
    localparam logic [31:0] SECOND_MS = 32'd1000;
    localparam logic [31:0] MINUTE_MS = 32'd60000;
    localparam int          MS_PER_S  = 1000;

    // Field and register widths
    localparam int TIME_W  = 32;
    localparam int CID_W   = 4;
    localparam int CNT_W   = 32;
    localparam int MPS_W   = 7;
    localparam int MPM_W   = 9;
    localparam int CMPM_W  = 7;
    localparam int CD_W    = 12;
    localparam int MCNT_W  = 9;
    localparam int CFG_W   = 12;
    localparam int CFGA_W  = 2;
    localparam int CMP_W   = 13;

    // Cooldown seconds from ms: dividend width and reciprocal of 1000,
    // exact for every dividend below 2^22 (ceil(2^32 / 1000), shift by 32)
    localparam int                 DIV_W      = 22;
    localparam int                 RECIP_W    = 23;
    localparam int                 RECIP_SH   = 32;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 23'd4294968;

    // Configuration register indexes
    typedef enum logic [CFGA_W-1:0] {
        CFG_MAX_PER_SECOND        = 2'd0,
        CFG_MAX_PER_MINUTE        = 2'd1,
        CFG_CLIENT_MAX_PER_MINUTE = 2'd2,
        CFG_COOLDOWN_SECS         = 2'd3
    } t_cfg_idx;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_CLIENT = 2'd0,
        REQ_GLOBAL = 2'd1,
        REQ_RESET  = 2'd2,
        REQ_STATUS = 2'd3
    } t_req;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_all;
        logic cool_clear;
        logic pop_sec;
        logic pop_min;
        logic pop_cli;
        logic set_cool;
        logic push;
        logic push_cli;
        logic inc_accept;
        logic inc_reject;
        logic rem_start;
        logic rem_step;
        logic out_load;
        logic admit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_req req_type;
        logic cooling;
        logic cool_expired;
        logic sec_exp;
        logic min_exp;
        logic cli_exp;
        logic glob_hit;
        logic cli_hit;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/swrl_ctrl.sv
// Controller state machine of the rate limiter.
module swrl_ctrl
    import swrl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE = 13'h0001,
        S_DISP = 13'h0002,
        S_SRD  = 13'h0004,
        S_SCK  = 13'h0008,
        S_MRD  = 13'h0010,
        S_MCK  = 13'h0020,
        S_GLIM = 13'h0040,
        S_CRD  = 13'h0080,
        S_CCK  = 13'h0100,
        S_CLIM = 13'h0200,
        S_REM  = 13'h0400,
        S_DIV  = 13'h0800,
        S_FIN  = 13'h1000
    } t_state;

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence one item
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                case (i_stat.req_type)
                    REQ_RESET: begin
                        o_cmd.clr_all = 1'b1;
                        n_state       = S_REM;
                    end
                    REQ_STATUS: n_state = S_REM;
                    default: begin
                        if (i_stat.cooling && !i_stat.cool_expired) begin
                            o_cmd.inc_reject = 1'b1;
                            n_state          = S_REM;
                        end else begin
                            o_cmd.cool_clear = i_stat.cooling;
                            n_state          = S_SRD;
                        end
                    end
                endcase
            end
            S_SRD: n_state = S_SCK;
            S_SCK: begin
                if (i_stat.sec_exp) begin
                    o_cmd.pop_sec = 1'b1;
                    n_state       = S_SRD;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_MRD: n_state = S_MCK;
            S_MCK: begin
                if (i_stat.min_exp) begin
                    o_cmd.pop_min = 1'b1;
                    n_state       = S_MRD;
                end else begin
                    n_state = S_GLIM;
                end
            end
            S_GLIM: begin
                if (i_stat.glob_hit) begin
                    o_cmd.set_cool   = 1'b1;
                    o_cmd.inc_reject = 1'b1;
                    n_state          = S_REM;
                end else if (i_stat.req_type == REQ_CLIENT) begin
                    n_state = S_CRD;
                end else begin
                    o_cmd.push       = 1'b1;
                    o_cmd.inc_accept = 1'b1;
                    o_cmd.admit      = 1'b1;
                    n_state          = S_REM;
                end
            end
            S_CRD: n_state = S_CCK;
            S_CCK: begin
                if (i_stat.cli_exp) begin
                    o_cmd.pop_cli = 1'b1;
                    n_state       = S_CRD;
                end else begin
                    n_state = S_CLIM;
                end
            end
            S_CLIM: begin
                if (i_stat.cli_hit) begin
                    o_cmd.inc_reject = 1'b1;
                end else begin
                    o_cmd.push       = 1'b1;
                    o_cmd.push_cli   = 1'b1;
                    o_cmd.inc_accept = 1'b1;
                    o_cmd.admit      = 1'b1;
                end
                n_state = S_REM;
            end
            S_REM: begin
                o_cmd.rem_start = 1'b1;
                n_state         = S_DIV;
            end
            // Seconds elapsed come from one registered multiply
            S_DIV: begin
                o_cmd.rem_step = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: rtl/swrl_dp.sv
// Datapath of the rate limiter: logs, counters, cooldown divider, result register.
module swrl_dp
    import swrl_pkg::*;
#(
    parameter int SECOND_DEPTH = SECOND_DEPTH_DEF,
    parameter int MINUTE_DEPTH = MINUTE_DEPTH_DEF,
    parameter int CLIENT_DEPTH = CLIENT_DEPTH_DEF,
    parameter int NUM_CLIENTS  = NUM_CLIENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [CFGA_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    // input item
    input  logic               i_in_take,
    input  logic [1:0]         i_req_type,
    input  logic [CID_W-1:0]   i_client_id,
    input  logic [TIME_W-1:0]  i_now_ms,
    // result item
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_admitted,
    output logic [CD_W-1:0]    o_cooldown_left_s,
    output logic [MCNT_W-1:0]  o_minute_count,
    output logic [CNT_W-1:0]   o_admitted_total,
    output logic [CNT_W-1:0]   o_refused_total,
    // control
    input  t_cmd               i_cmd,
    output t_stat              o_stat
);

    `include "assert_macros.svh"

    localparam int SAW = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
    localparam int SFW = $clog2(SECOND_DEPTH + 1);
    localparam int MAW = (MINUTE_DEPTH > 1) ? $clog2(MINUTE_DEPTH) : 1;
    localparam int MFW = $clog2(MINUTE_DEPTH + 1);
    localparam int CAW = (CLIENT_DEPTH > 1) ? $clog2(CLIENT_DEPTH) : 1;
    localparam int CFW = $clog2(CLIENT_DEPTH + 1);
    localparam int CIW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int CLN = NUM_CLIENTS * CLIENT_DEPTH;
    localparam int CLW = (CLN > 1) ? $clog2(CLN) : 1;
    localparam int PRW = DIV_W + RECIP_W;

    // Configuration registers
    logic [MPS_W-1:0]  r_max_sec;
    logic [MPM_W-1:0]  r_max_min;
    logic [CMPM_W-1:0] r_cli_max;
    logic [CD_W-1:0]   r_cd_secs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sec <= MPS_W'(10);
            r_max_min <= MPM_W'(100);
            r_cli_max <= CMPM_W'(30);
            r_cd_secs <= CD_W'(60);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MAX_PER_SECOND:        r_max_sec <= i_cfg_wdata[MPS_W-1:0];
                CFG_MAX_PER_MINUTE:        r_max_min <= i_cfg_wdata[MPM_W-1:0];
                CFG_CLIENT_MAX_PER_MINUTE: r_cli_max <= i_cfg_wdata[CMPM_W-1:0];
                CFG_COOLDOWN_SECS:         r_cd_secs <= i_cfg_wdata[CD_W-1:0];
                default: ;
            endcase
        end
    end

    // Map client id onto the client range
    logic [CIW-1:0] cid_map [1 << CID_W];
    for (genvar g = 0; g < (1 << CID_W); g++) begin : g_cid
        assign cid_map[g] = CIW'(g % NUM_CLIENTS);
    end

    // Latch the accepted item
    logic [1:0]        r_type;
    logic [CIW-1:0]    r_cid;
    logic [TIME_W-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_in_take) begin
            r_type <= i_req_type;
            r_cid  <= cid_map[i_client_id];
            r_now  <= i_now_ms;
        end
    end

    // Window state
    logic [SAW-1:0]    r_sec_head;
    logic [SFW-1:0]    r_sec_fill;
    logic [MAW-1:0]    r_min_head;
    logic [MFW-1:0]    r_min_fill;
    logic [CAW-1:0]    r_cli_head [NUM_CLIENTS];
    logic [CFW-1:0]    r_cli_fill [NUM_CLIENTS];
    logic              r_cooling;
    logic [TIME_W-1:0] r_cool_start;
    logic [CNT_W-1:0]  r_acc_cnt;
    logic [CNT_W-1:0]  r_rej_cnt;

    logic [CAW-1:0] cur_cli_head;
    logic [CFW-1:0] cur_cli_fill;
    assign cur_cli_head = r_cli_head[r_cid];
    assign cur_cli_fill = r_cli_fill[r_cid];

    // Write positions: head plus fill, wrapped once
    logic [SFW:0] sec_sum;
    logic [MFW:0] min_sum;
    logic [CFW:0] cli_sum;
    logic [SAW-1:0] sec_wa;
    logic [MAW-1:0] min_wa;
    logic [CAW-1:0] cli_wa;

    always_comb begin
        sec_sum = (SFW+1)'(r_sec_head) + (SFW+1)'(r_sec_fill);
        min_sum = (MFW+1)'(r_min_head) + (MFW+1)'(r_min_fill);
        cli_sum = (CFW+1)'(cur_cli_head) + (CFW+1)'(cur_cli_fill);
        if (sec_sum >= (SFW+1)'(SECOND_DEPTH)) sec_sum = sec_sum - (SFW+1)'(SECOND_DEPTH);
        if (min_sum >= (MFW+1)'(MINUTE_DEPTH)) min_sum = min_sum - (MFW+1)'(MINUTE_DEPTH);
        if (cli_sum >= (CFW+1)'(CLIENT_DEPTH)) cli_sum = cli_sum - (CFW+1)'(CLIENT_DEPTH);
        sec_wa = sec_sum[SAW-1:0];
        min_wa = min_sum[MAW-1:0];
        cli_wa = cli_sum[CAW-1:0];
    end

    logic [CLW-1:0] cli_base;
    logic [CLW-1:0] cli_rd_addr;
    logic [CLW-1:0] cli_wr_addr;
    assign cli_base    = CLW'(r_cid) * CLW'(CLIENT_DEPTH);
    assign cli_rd_addr = cli_base + CLW'(cur_cli_head);
    assign cli_wr_addr = cli_base + CLW'(cli_wa);

    // Timestamp logs
    logic [TIME_W-1:0] sec_mem [SECOND_DEPTH];
    logic [TIME_W-1:0] min_mem [MINUTE_DEPTH];
    logic [TIME_W-1:0] cli_mem [CLN];
    logic [TIME_W-1:0] r_sec_rd, r_min_rd, r_cli_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_sec_fill < SFW'(SECOND_DEPTH))) sec_mem[sec_wa] <= r_now;
        r_sec_rd <= sec_mem[r_sec_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_min_fill < MFW'(MINUTE_DEPTH))) min_mem[min_wa] <= r_now;
        r_min_rd <= min_mem[r_min_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_cli && (cur_cli_fill < CFW'(CLIENT_DEPTH))) begin
            cli_mem[cli_wr_addr] <= r_now;
        end
        r_cli_rd <= cli_mem[cli_rd_addr];
    end

    // Head and fill bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all || i_cmd.cool_clear) begin
            r_sec_head <= '0;
            r_sec_fill <= '0;
            r_min_head <= '0;
            r_min_fill <= '0;
        end else begin
            if (i_cmd.pop_sec) begin
                r_sec_head <= (r_sec_head == SAW'(SECOND_DEPTH - 1)) ? '0
                              : r_sec_head + SAW'(1);
                r_sec_fill <= r_sec_fill - SFW'(1);
            end else if (i_cmd.push && (r_sec_fill < SFW'(SECOND_DEPTH))) begin
                r_sec_fill <= r_sec_fill + SFW'(1);
            end
            if (i_cmd.pop_min) begin
                r_min_head <= (r_min_head == MAW'(MINUTE_DEPTH - 1)) ? '0
                              : r_min_head + MAW'(1);
                r_min_fill <= r_min_fill - MFW'(1);
            end else if (i_cmd.push && (r_min_fill < MFW'(MINUTE_DEPTH))) begin
                r_min_fill <= r_min_fill + MFW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                r_cli_head[i] <= '0;
                r_cli_fill[i] <= '0;
            end
        end else if (i_cmd.pop_cli) begin
            r_cli_head[r_cid] <= (cur_cli_head == CAW'(CLIENT_DEPTH - 1)) ? '0
                                 : cur_cli_head + CAW'(1);
            r_cli_fill[r_cid] <= cur_cli_fill - CFW'(1);
        end else if (i_cmd.push_cli && (cur_cli_fill < CFW'(CLIENT_DEPTH))) begin
            r_cli_fill[r_cid] <= cur_cli_fill + CFW'(1);
        end
    end

    // Cooldown flag and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_cooling    <= 1'b0;
            r_cool_start <= '0;
            r_acc_cnt    <= '0;
            r_rej_cnt    <= '0;
        end else begin
            if (i_cmd.set_cool) begin
                r_cooling    <= 1'b1;
                r_cool_start <= r_now;
            end else if (i_cmd.cool_clear) begin
                r_cooling <= 1'b0;
            end
            if (i_cmd.inc_accept) r_acc_cnt <= r_acc_cnt + CNT_W'(1);
            if (i_cmd.inc_reject) r_rej_cnt <= r_rej_cnt + CNT_W'(1);
        end
    end

    // Cooldown elapsed time against the limit in ms
    logic [TIME_W-1:0] cool_diff;
    logic [DIV_W-1:0]  cd_ms;
    logic              cool_expired;
    assign cool_diff    = r_now - r_cool_start;
    assign cd_ms        = DIV_W'(r_cd_secs) * DIV_W'(MS_PER_S);
    assign cool_expired = (cool_diff >= TIME_W'(cd_ms));

    // Limit checks against the smaller of limit and depth
    function automatic logic at_limit(input logic [CMP_W-1:0] fill,
                                      input logic [CMP_W-1:0] limit,
                                      input logic [CMP_W-1:0] depth);
        logic [CMP_W-1:0] eff;
        eff = (limit < depth) ? limit : depth;
        return fill >= eff;
    endfunction

    logic sec_hit, min_hit;
    assign sec_hit = at_limit(CMP_W'(r_sec_fill), CMP_W'(r_max_sec), CMP_W'(SECOND_DEPTH));
    assign min_hit = at_limit(CMP_W'(r_min_fill), CMP_W'(r_max_min), CMP_W'(MINUTE_DEPTH));

    // Remaining cooldown: seconds from ms by reciprocal multiplication;
    // the elapsed ms stay below 2^22 whenever the cooldown is still running
    logic [DIV_W-1:0] r_rem;
    logic [CD_W-1:0]  r_quo;
    logic             r_rem_zero;
    logic [PRW-1:0]   quo_prod;
    assign quo_prod = PRW'(r_rem) * PRW'(RECIP_1000);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rem_start) begin
            r_rem      <= cool_diff[DIV_W-1:0];
            r_rem_zero <= !(r_cooling && !cool_expired);
        end
        if (i_cmd.rem_step) begin
            r_quo <= quo_prod[RECIP_SH +: CD_W];
        end
    end

    // Result register
    logic             r_out_valid;
    logic             r_admitted;
    logic [CD_W-1:0]  r_cd_left;
    logic [MCNT_W-1:0] r_min_cnt;
    logic [CNT_W-1:0] r_out_acc;
    logic [CNT_W-1:0] r_out_rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    logic r_admit_hold;
    always_ff @(posedge i_clk) begin
        if (i_in_take) begin
            r_admit_hold <= 1'b0;
        end else if (i_cmd.admit) begin
            r_admit_hold <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_admitted <= r_admit_hold;
            r_cd_left  <= r_rem_zero ? '0 : r_cd_secs - r_quo;
            r_min_cnt  <= MCNT_W'(r_min_fill);
            r_out_acc  <= r_acc_cnt;
            r_out_rej  <= r_rej_cnt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_admitted        = r_admitted;
    assign o_cooldown_left_s = r_cd_left;
    assign o_minute_count    = r_min_cnt;
    assign o_admitted_total  = r_out_acc;
    assign o_refused_total   = r_out_rej;

    // Status to controller
    always_comb begin
        o_stat              = '0;
        o_stat.req_type     = t_req'(r_type);
        o_stat.cooling      = r_cooling;
        o_stat.cool_expired = cool_expired;
        o_stat.sec_exp      = (r_sec_fill != '0) && ((r_now - r_sec_rd) > SECOND_MS);
        o_stat.min_exp      = (r_min_fill != '0) && ((r_now - r_min_rd) > MINUTE_MS);
        o_stat.cli_exp      = (cur_cli_fill != '0) && ((r_now - r_cli_rd) > MINUTE_MS);
        o_stat.glob_hit     = sec_hit || min_hit;
        o_stat.cli_hit      = at_limit(CMP_W'(cur_cli_fill), CMP_W'(r_cli_max),
                                       CMP_W'(CLIENT_DEPTH));
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

    // Properties of the bookkeeping
    logic fill_ok, cleared_ok;
    assign fill_ok    = (r_sec_fill <= SFW'(SECOND_DEPTH)) && (r_min_fill <= MFW'(MINUTE_DEPTH));
    assign cleared_ok = !r_cooling && (r_acc_cnt == '0) && (r_rej_cnt == '0);

    `SWRL_ASSERT_ALWAYS(a_fill_bound, fill_ok, "log fill beyond depth")
    `SWRL_ASSERT_NEXT(a_clear_all, i_cmd.clr_all, cleared_ok, "reset item left state")
    `SWRL_ASSERT_NEXT(a_cool_start, i_cmd.set_cool, r_cooling && (r_cool_start == r_now), "no cooldown")
    `SWRL_ASSERT_NEXT(a_push_min, i_cmd.push && !i_cmd.pop_min, r_min_fill == $past(r_min_fill) + MFW'(1), "minute push lost")

endmodule

// File: rtl/sliding_window_rate_limiter_unit.sv
// Reset and status items and requests refused in cooldown skip the window checks;
//   a global-only request checks the global logs, a client request also its client log.
// One item at a time: each pruned entry costs a log read and a check, the remaining
//   cooldown one registered reciprocal multiply; next item once the result is loaded.
// Reset (i_rst_n low, synchronous) empties all logs, clears the cooldown and
//   both totals and loads the register defaults.
module sliding_window_rate_limiter_unit
    import swrl_pkg::*;
#(
    parameter int SECOND_DEPTH = SECOND_DEPTH_DEF,
    parameter int MINUTE_DEPTH = MINUTE_DEPTH_DEF,
    parameter int CLIENT_DEPTH = CLIENT_DEPTH_DEF,
    parameter int NUM_CLIENTS  = NUM_CLIENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [CFGA_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // request stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [39:0]       i_s_axis_tdata,  // client_id[3:0], now_ms[35:4], zero pad
    input  logic [1:0]        i_s_axis_tuser,  // req_type[1:0]
    // result stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [87:0]       o_m_axis_tdata   // admitted[0], cooldown_left_s[12:1],
                                               // minute_count[21:13],
                                               // admitted_total[53:22],
                                               // refused_total[85:54], zero pad
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_take;

    logic              out_admitted;
    logic [CD_W-1:0]   out_cd_left;
    logic [MCNT_W-1:0] out_min_cnt;
    logic [CNT_W-1:0]  out_acc;
    logic [CNT_W-1:0]  out_rej;

    assign in_take = i_s_axis_tvalid && o_s_axis_tready;

    swrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    swrl_dp #(
        .SECOND_DEPTH (SECOND_DEPTH),
        .MINUTE_DEPTH (MINUTE_DEPTH),
        .CLIENT_DEPTH (CLIENT_DEPTH),
        .NUM_CLIENTS  (NUM_CLIENTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_take         (in_take),
        .i_req_type        (i_s_axis_tuser),
        .i_client_id       (i_s_axis_tdata[CID_W-1:0]),
        .i_now_ms          (i_s_axis_tdata[CID_W+TIME_W-1:CID_W]),
        .i_out_ready       (i_m_axis_tready),
        .o_out_valid       (o_m_axis_tvalid),
        .o_admitted        (out_admitted),
        .o_cooldown_left_s (out_cd_left),
        .o_minute_count    (out_min_cnt),
        .o_admitted_total  (out_acc),
        .o_refused_total   (out_rej),
        .i_cmd             (cmd),
        .o_stat            (stat)
    );

    // Pack the result item
    assign o_m_axis_tdata = {2'b00, out_rej, out_acc, out_min_cnt, out_cd_left, out_admitted};

endmodule
